// File: src/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Used by the channel interfaces, the controller, the datapath and the checker.
// Depends on nothing.
package tcw_pkg;

    // Payload field widths.
    localparam int TYPE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int LINE_W   = 5;
    localparam int COLUMN_W = 7;
    localparam int CELL_W   = CHAR_W + COLOR_W;

    // Width of the read address product: line times column count plus column.
    localparam int RD_PROD_W = LINE_W + COLUMN_W + 2;

    // Request codes.
    localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_rdy;       // request channel may transfer
        logic decode;       // act on the held request
        logic read_cap;     // capture read data of a cell read
        logic sweep_start;  // restart the sweep counter
        logic copy_step;    // scroll: move one cell up one row
        logic zero_step;    // clear one cell
        logic out_load;     // load the response register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;     // a request is offered
        logic is_clear;     // held request is a clear
        logic is_read;      // held request is a cell read
        logic need_scroll;  // held put moves down from the last row
        logic copy_last;    // sweep is at the last cell of the copy
        logic sweep_last;   // sweep is at the last cell of the store
        logic out_busy;     // response register is full and stalled
    } status_t;

endpackage

// File: src/tcw_req_if.sv
// Request channel of the text console writer: handshake plus request fields.
// Depends on tcw_pkg.
interface tcw_req_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::TYPE_W-1:0]   req_type;
    logic [tcw_pkg::CHAR_W-1:0]   char_code;
    logic [tcw_pkg::COLOR_W-1:0]  color;
    logic [tcw_pkg::LINE_W-1:0]   read_line;
    logic [tcw_pkg::COLUMN_W-1:0] read_column;

    modport source (output valid, req_type, char_code, color, read_line, read_column,
                    input ready);
    modport sink   (input valid, req_type, char_code, color, read_line, read_column,
                    output ready);
endinterface

// File: src/tcw_rsp_if.sv
// Response channel of the text console writer: handshake plus result fields.
// Depends on tcw_pkg.
interface tcw_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [tcw_pkg::LINE_W-1:0]   cursor_line;
    logic [tcw_pkg::COLUMN_W-1:0] cursor_column;
    logic [tcw_pkg::CHAR_W-1:0]   cell_char;
    logic [tcw_pkg::COLOR_W-1:0]  cell_color;

    modport source (output valid, cursor_line, cursor_column, cell_char, cell_color,
                    input ready);
    modport sink   (input valid, cursor_line, cursor_column, cell_char, cell_color,
                    output ready);
endinterface

// File: src/tcw_controller.sv
// Sequencing state machine of the text console writer.
// Depends on tcw_pkg; drives the datapath through tcw_pkg::cmd_t.
module tcw_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::status_t  st,
    output tcw_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_BOOT       = 3'd0;
    localparam logic [2:0] S_IDLE       = 3'd1;
    localparam logic [2:0] S_DECODE     = 3'd2;
    localparam logic [2:0] S_READ       = 3'd3;
    localparam logic [2:0] S_SCROLL     = 3'd4;
    localparam logic [2:0] S_SCROLL_CLR = 3'd5;
    localparam logic [2:0] S_CLEAR      = 3'd6;
    localparam logic [2:0] S_RESULT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_BOOT:
            begin
                cmd.zero_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_rdy = 1'b1;
                if (st.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode      = 1'b1;
                cmd.sweep_start = 1'b1;
                if (st.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (st.is_read)
                begin
                    state_next = S_READ;
                end
                else if (st.need_scroll)
                begin
                    state_next = S_SCROLL;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_READ:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_RESULT;
            end
            S_SCROLL:
            begin
                cmd.copy_step = 1'b1;
                if (st.copy_last)
                begin
                    state_next = S_SCROLL_CLR;
                end
            end
            S_SCROLL_CLR, S_CLEAR:
            begin
                cmd.zero_step = 1'b1;
                if (st.sweep_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BOOT;
            end
        endcase
    end

endmodule

// File: src/tcw_datapath.sv
// Datapath of the text console writer: request hold, cursor, cell store,
// sweep counter, write stage and response register.
// Depends on tcw_pkg, tcw_req_if and tcw_rsp_if.
module tcw_datapath #(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_pkg::cmd_t     cmd,
    output tcw_pkg::status_t  st,
    tcw_req_if.sink           req,
    tcw_rsp_if.source         rsp
);

    localparam int TOTAL    = ROWS * COLS;
    localparam int COPY_END = (ROWS - 1) * COLS;
    localparam int AW       = $clog2(TOTAL);
    localparam int RW       = $clog2(ROWS);
    localparam int CW       = $clog2(COLS);
    localparam int CELL_W   = tcw_pkg::CELL_W;

    // Cell store: color in the upper byte, character in the lower byte.
    logic [CELL_W-1:0] mem [TOTAL];

    // Held request.
    logic [tcw_pkg::TYPE_W-1:0]   type_reg,  type_next;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg,  char_next;
    logic [tcw_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic [tcw_pkg::LINE_W-1:0]   rline_reg, rline_next;
    logic [tcw_pkg::COLUMN_W-1:0] rcol_reg,  rcol_next;

    // Cursor and sweep counter.
    logic [RW-1:0] row_reg,   row_next;
    logic [CW-1:0] col_reg,   col_next;
    logic [AW-1:0] sweep_reg, sweep_next;

    // Write stage; a copy takes its data from the read register.
    logic              wr_en_reg,   wr_en_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [CELL_W-1:0] wr_data_reg, wr_data_next;

    logic [CELL_W-1:0] rdata_reg;
    logic [AW-1:0]     rd_addr;

    logic              rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0] cell_reg,  cell_next;

    // Response register.
    logic                         out_valid_reg,  out_valid_next;
    logic [tcw_pkg::LINE_W-1:0]   out_line_reg,   out_line_next;
    logic [tcw_pkg::COLUMN_W-1:0] out_column_reg, out_column_next;
    logic [CELL_W-1:0]            out_cell_reg,   out_cell_next;

    logic                          load_req;
    logic                          rd_in_range;
    logic [tcw_pkg::RD_PROD_W-1:0] rd_full;
    logic [AW-1:0]                 rd_cell_addr;
    logic [AW-1:0]                 cur_addr;
    logic                          row_at_end;
    logic                          col_at_end;
    logic                          put_active;
    logic [7:0]                    row_wide;
    logic [7:0]                    col_wide;

    assign load_req = cmd.in_rdy && req.valid;

    assign rd_in_range = ({2'b00, rline_reg} < 7'(ROWS)) && ({1'b0, rcol_reg} < 8'(COLS));
    assign rd_full = tcw_pkg::RD_PROD_W'(rline_reg) * tcw_pkg::RD_PROD_W'(COLS)
                   + tcw_pkg::RD_PROD_W'(rcol_reg);
    assign rd_cell_addr = rd_full[AW-1:0];

    assign cur_addr   = AW'(row_reg) * AW'(COLS) + AW'(col_reg);
    assign row_at_end = (row_reg == RW'(ROWS - 1));
    assign col_at_end = (col_reg == CW'(COLS - 1));
    assign put_active = (type_reg == tcw_pkg::REQ_PUT) && (char_reg != tcw_pkg::CHAR_NUL);

    // Cursor values as reported, masked to the field widths.
    assign row_wide = 8'(row_reg);
    assign col_wide = 8'(col_reg);

    always_comb
    begin
        st.in_valid    = req.valid;
        st.is_clear    = (type_reg == tcw_pkg::REQ_CLEAR);
        st.is_read     = (type_reg == tcw_pkg::REQ_READ);
        st.need_scroll = put_active && row_at_end
                       && ((char_reg == tcw_pkg::CHAR_NEWLINE) || col_at_end);
        st.copy_last   = (sweep_reg == AW'(COPY_END - 1));
        st.sweep_last  = (sweep_reg == AW'(TOTAL - 1));
        st.out_busy    = out_valid_reg && !rsp.ready;
    end

    always_comb
    begin
        type_next       = type_reg;
        char_next       = char_reg;
        color_next      = color_reg;
        rline_next      = rline_reg;
        rcol_next       = rcol_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        sweep_next      = sweep_reg;
        wr_en_next      = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_copy_next    = wr_copy_reg;
        wr_data_next    = wr_data_reg;
        rd_addr         = rd_cell_addr;
        rd_ok_next      = rd_ok_reg;
        cell_next       = cell_reg;
        out_valid_next  = out_valid_reg;
        out_line_next   = out_line_reg;
        out_column_next = out_column_reg;
        out_cell_next   = out_cell_reg;

        if (load_req)
        begin
            type_next  = req.req_type;
            char_next  = req.char_code;
            color_next = req.color;
            rline_next = req.read_line;
            rcol_next  = req.read_column;
        end

        if (cmd.decode)
        begin
            cell_next  = '0;
            rd_ok_next = rd_in_range;
            case (type_reg)
                tcw_pkg::REQ_PUT:
                begin
                    if (put_active)
                    begin
                        if (char_reg != tcw_pkg::CHAR_NEWLINE)
                        begin
                            wr_en_next   = 1'b1;
                            wr_addr_next = cur_addr;
                            wr_copy_next = 1'b0;
                            wr_data_next = {color_reg, char_reg};
                        end
                        // A newline or a write in the last column starts the next row;
                        // on the last row the scroll sweep follows instead.
                        if ((char_reg == tcw_pkg::CHAR_NEWLINE) || col_at_end)
                        begin
                            col_next = '0;
                            if (!row_at_end)
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + CW'(1);
                        end
                    end
                end
                tcw_pkg::REQ_CLEAR:
                begin
                    row_next = '0;
                    col_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.read_cap)
        begin
            cell_next = rd_ok_reg ? rdata_reg : '0;
        end

        if (cmd.sweep_start)
        begin
            sweep_next = '0;
        end
        else if (cmd.copy_step || cmd.zero_step)
        begin
            sweep_next = sweep_reg + AW'(1);
        end

        // The cell one row down is read now and written in the next cycle from the read register.
        if (cmd.copy_step)
        begin
            rd_addr      = sweep_reg + AW'(COLS);
            wr_en_next   = 1'b1;
            wr_addr_next = sweep_reg;
            wr_copy_next = 1'b1;
        end

        if (cmd.zero_step)
        begin
            wr_en_next   = 1'b1;
            wr_addr_next = sweep_reg;
            wr_copy_next = 1'b0;
            wr_data_next = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_line_next   = row_wide[tcw_pkg::LINE_W-1:0];
            out_column_next = col_wide[tcw_pkg::COLUMN_W-1:0];
            out_cell_next   = cell_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            sweep_reg     <= '0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            sweep_reg     <= sweep_next;
            wr_en_reg     <= wr_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        char_reg       <= char_next;
        color_reg      <= color_next;
        rline_reg      <= rline_next;
        rcol_reg       <= rcol_next;
        wr_addr_reg    <= wr_addr_next;
        wr_copy_reg    <= wr_copy_next;
        wr_data_reg    <= wr_data_next;
        rd_ok_reg      <= rd_ok_next;
        cell_reg       <= cell_next;
        out_line_reg   <= out_line_next;
        out_column_reg <= out_column_next;
        out_cell_reg   <= out_cell_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_copy_reg ? rdata_reg : wr_data_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign req.ready         = cmd.in_rdy;
    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_line   = out_line_reg;
    assign rsp.cursor_column = out_column_reg;
    assign rsp.cell_char     = out_cell_reg[tcw_pkg::CHAR_W-1:0];
    assign rsp.cell_color    = out_cell_reg[CELL_W-1:tcw_pkg::CHAR_W];

endmodule

// File: src/text_console_writer_unit.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_controller, tcw_datapath.
//
//  Channel  Direction  Carries
//  req      in         req_type, char_code, color, read_line, read_column
//  rsp      out        cursor_line, cursor_column, cell_char, cell_color
//
// A put, a null or an unused request passes the decode and result states on its way to a
// valid response, a cell read also the read state (one registered read of the cell store).
// The request channel opens again in the cycle after the response is loaded.
// A put that scrolls and a clear each add a sweep:
// the single write port of the cell store walks every cell once.
// After reset the store is cleared with req.ready low.
// One request is in work at a time; a stalled response holds the next one
// in its last step, and the request channel stays closed until it is loaded.
module text_console_writer_unit #(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t st;

    tcw_controller u_controller
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .st    (st),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// File: src/tcw_checker.sv
// Port-level checks of the text console writer and their binding.
// Depends on tcw_pkg; bound to text_console_writer_unit.
module tcw_checker #(
    parameter int ROWS = 25,
    parameter int COLS = 80
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [tcw_pkg::LINE_W-1:0]   cursor_line,
    input logic [tcw_pkg::COLUMN_W-1:0] cursor_column,
    input logic [tcw_pkg::CHAR_W-1:0]   cell_char,
    input logic [tcw_pkg::COLOR_W-1:0]  cell_color
);

    // Requests are worked one at a time, so a transfer closes the channel.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request channel stayed open after a transfer");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({cursor_line, cursor_column, cell_char, cell_color}))
        else $error("stalled response changed");

    // The reported cursor always lies on the screen.
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((ROWS > 32) || ({27'd0, cursor_line} < ROWS))
            && ({25'd0, cursor_column} < COLS))
        else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .cursor_line   (rsp.cursor_line),
    .cursor_column (rsp.cursor_column),
    .cell_char     (rsp.cell_char),
    .cell_color    (rsp.cell_color)
);

// File: bench/tb_text_console_writer_unit.sv
// Testbench of the text console writer unit: directed and random console requests.
// Every response is checked against a typed-in value or a mirror of the cell store and the cursor.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if and text_console_writer_unit.
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS         = 25;
    localparam int COLS         = 80;
    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_ITEMS  = 150;
    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 20;

    // The fourth request code has no meaning in the block.
    localparam logic [tcw_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [tcw_pkg::TYPE_W-1:0]   kind;
        logic [tcw_pkg::CHAR_W-1:0]   char_code;
        logic [tcw_pkg::COLOR_W-1:0]  color;
        logic [tcw_pkg::LINE_W-1:0]   line;
        logic [tcw_pkg::COLUMN_W-1:0] column;
    } console_req_t;

    typedef struct packed {
        logic [tcw_pkg::LINE_W-1:0]   line_pos;
        logic [tcw_pkg::COLUMN_W-1:0] column_pos;
        logic [tcw_pkg::CHAR_W-1:0]   cell_char;
        logic [tcw_pkg::COLOR_W-1:0]  cell_color;
    } console_rsp_t;

    typedef struct packed {
        console_req_t stim;
        logic         typed;
        console_rsp_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tcw_req_if req_ch();
    tcw_rsp_if rsp_ch();

    text_console_writer_unit #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Mirror of the console state.
    logic [tcw_pkg::CELL_W-1:0]   screen_mirror [ROWS*COLS];
    logic [tcw_pkg::LINE_W-1:0]   cursor_row;
    logic [tcw_pkg::COLUMN_W-1:0] cursor_col;

    console_rsp_t pending_rsp [$];
    int           mismatches = 0;
    bit           quiet = 1'b0;

    // Rows with a typed-in response can be read off directly; the others go to the mirror.
    directed_row_t directed_table [24] = '{
        '{'{tcw_pkg::REQ_READ, 8'hA5, 8'h5A, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'hFF, 5'd24, 7'd79}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'hFF, 8'h00, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'h0A, 8'h3C, 5'd25, 7'd80}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{REQ_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h00, 8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h41, 8'h1F, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd1, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd2, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h01, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd3, 8'h41, 8'h1F}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1'b1, '{5'd0, 7'd3, 8'hFF, 8'hFF}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd2}, 1'b1, '{5'd0, 7'd3, 8'h01, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd3}, 1'b1, '{5'd0, 7'd3, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h0A, 8'hAA, 5'd0, 7'd0}, 1'b1, '{5'd1, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h0A, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd2, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h7A, 8'h70, 5'd0, 7'd0}, 1'b0, '0},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd2, 7'd0}, 1'b0, '0},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd127}, 1'b0, '0},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd30, 7'd0}, 1'b0, '0},
        '{'{tcw_pkg::REQ_CLEAR, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1, '{5'd0, 7'd0, 8'h00, 8'h00}},
        '{'{tcw_pkg::REQ_PUT, 8'h80, 8'h55, 5'd0, 7'd0}, 1'b0, '0},
        '{'{REQ_UNUSED, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
        '{'{tcw_pkg::REQ_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b0, '0}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_mirror();
        for (int i = 0; i < ROWS * COLS; i++)
            screen_mirror[i] = '0;
        cursor_row = '0;
        cursor_col = '0;
    endfunction

    // Column 0 of the next row; from the last row the whole screen moves up instead.
    function automatic void advance_line();
        cursor_col = '0;
        if (cursor_row < ROWS - 1)
            cursor_row = cursor_row + 1'b1;
        else
        begin
            for (int i = 0; i < (ROWS - 1) * COLS; i++)
                screen_mirror[i] = screen_mirror[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < ROWS * COLS; i++)
                screen_mirror[i] = '0;
        end
    endfunction

    function automatic console_rsp_t console_apply(console_req_t r);
        console_rsp_t               res;
        logic [tcw_pkg::CELL_W-1:0] cell_word;
        cell_word = '0;
        case (r.kind)
            tcw_pkg::REQ_PUT:
            begin
                if (r.char_code == tcw_pkg::CHAR_NEWLINE)
                    advance_line();
                else if (r.char_code != tcw_pkg::CHAR_NUL)
                begin
                    screen_mirror[cursor_row * COLS + cursor_col] = {r.color, r.char_code};
                    if (cursor_col < COLS - 1)
                        cursor_col = cursor_col + 1'b1;
                    else
                        advance_line();
                end
            end
            tcw_pkg::REQ_CLEAR:
                clear_mirror();
            tcw_pkg::REQ_READ:
            begin
                if (r.line < ROWS && r.column < COLS)
                    cell_word = screen_mirror[r.line * COLS + r.column];
            end
            default:
                ;
        endcase
        res.line_pos   = cursor_row;
        res.column_pos = cursor_col;
        res.cell_char  = cell_word[tcw_pkg::CHAR_W-1:0];
        res.cell_color = cell_word[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        return res;
    endfunction

    task automatic issue_request(input console_req_t r, input logic typed,
                                 input console_rsp_t want);
        console_rsp_t predicted;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.kind;
        req_ch.char_code   <= r.char_code;
        req_ch.color       <= r.color;
        req_ch.read_line   <= r.line;
        req_ch.read_column <= r.column;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = console_apply(r);
        pending_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic maybe_idle();
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        console_req_t r;
        int           counted;
        int           mode;
        int           run_len;
        int           printable;
        bit           paused;
        counted = 0;
        paused  = 1'b0;
        clear_mirror();
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= tcw_pkg::REQ_PUT;
        req_ch.char_code   <= '0;
        req_ch.color       <= '0;
        req_ch.read_line   <= '0;
        req_ch.read_column <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_table[i])
        begin
            maybe_idle();
            issue_request(directed_table[i].stim, directed_table[i].typed,
                          directed_table[i].want);
        end

        // Bursts of text, of line feeds, of reads near the cursor, and of noise.
        while (counted < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                4, 5:    run_len = $urandom_range(5, 30);
                6, 7:    run_len = $urandom_range(3, 15);
                8:       run_len = $urandom_range(2, 6);
                default: run_len = $urandom_range(20, 120);
            endcase
            for (int n = 0; n < run_len && counted < RANDOM_ITEMS; n++)
            begin
                r.kind      = tcw_pkg::REQ_PUT;
                r.char_code = tcw_pkg::CHAR_W'($urandom_range(0, 255));
                r.color     = tcw_pkg::COLOR_W'($urandom_range(0, 255));
                r.line      = tcw_pkg::LINE_W'($urandom_range(0, 31));
                r.column    = tcw_pkg::COLUMN_W'($urandom_range(0, 127));
                // Printable codes skip the null and the newline.
                printable = $urandom_range(1, 254);
                if (printable >= tcw_pkg::CHAR_NEWLINE)
                    printable++;
                case (mode)
                    4, 5:
                        r.char_code = ($urandom_range(0, 1) == 0)
                                    ? tcw_pkg::CHAR_NEWLINE
                                    : tcw_pkg::CHAR_W'(printable);
                    6, 7:
                    begin
                        r.kind = tcw_pkg::REQ_READ;
                        if ($urandom_range(0, 7) != 0)
                        begin
                            r.line   = ($urandom_range(0, 1) == 0)
                                     ? cursor_row
                                     : tcw_pkg::LINE_W'($urandom_range(0, ROWS - 1));
                            r.column = tcw_pkg::COLUMN_W'($urandom_range(0, COLS - 1));
                        end
                    end
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0:       r.kind = tcw_pkg::REQ_CLEAR;
                            1:       r.kind = REQ_UNUSED;
                            2:       r.kind = tcw_pkg::REQ_READ;
                            default: r.kind = tcw_pkg::REQ_PUT;
                        endcase
                    end
                    default:
                        r.char_code = ($urandom_range(0, 39) == 0)
                                    ? tcw_pkg::CHAR_NEWLINE
                                    : tcw_pkg::CHAR_W'(printable);
                endcase

                quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
                // Once, let every outstanding response come back before going on.
                if (!paused && counted >= RANDOM_ITEMS / 2)
                begin
                    paused = 1'b1;
                    req_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_rsp.size() != 0)
                        @(posedge clk);
                end
                maybe_idle();
                issue_request(r, 1'b0, '0);
                if (!(r.kind == REQ_UNUSED
                      || (r.kind == tcw_pkg::REQ_PUT && r.char_code == tcw_pkg::CHAR_NUL)))
                    counted++;
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_rsp
        console_rsp_t got;
        console_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.cursor_line, rsp_ch.cursor_column, rsp_ch.cell_char,
                    rsp_ch.cell_color};
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected response: line %0d column %0d char %02h color %02h",
                         $time, got.line_pos, got.column_pos, got.cell_char, got.cell_color);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $display("%0t: expected line %0d column %0d char %02h color %02h, %s",
                             $time, want.line_pos, want.column_pos, want.cell_char,
                             want.cell_color, "got:");
                    $display("%0t: actual   line %0d column %0d char %02h color %02h",
                             $time, got.line_pos, got.column_pos, got.cell_char,
                             got.cell_color);
                end
            end
        end
    end

    // Ends a hung run: the longest legal quiet stretch is a scroll or clear plus a stall.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
